[rtl/core/assert_macros.svh]
// Assertion macros used by the checker of the fan curve block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCMI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fan curve check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCMI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fan curve check failed");

`endif

[rtl/core/fcmi_pkg.sv]
// Package with the widths, register codes and reset values of the fan curve block.
package fcmi_pkg;

	localparam int NUM_POINTS         = 7;
	localparam int DEFAULT_MAX_POINTS = 7;
	localparam int TEMP_W             = 12;
	localparam int SPEED_W            = 14;
	localparam int COUNT_W            = 3;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 26;

	localparam logic [SPEED_W-1:0] FULL_SPEED = 14'd10000;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT0 = 3'd1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd6;
	localparam logic [CFG_DATA_W-1:0] POINT_RESET [NUM_POINTS] = '{
		26'd10487760, 26'd13110200, 26'd15733140, 26'd18356580,
		26'd20980020, 26'd23602960, 26'd0
	};

	// Field extraction from a packed curve point.
	function automatic logic [TEMP_W-1:0] pt_temp(input logic [CFG_DATA_W-1:0] p);
		return p[CFG_DATA_W-1:SPEED_W];
	endfunction

	function automatic logic [SPEED_W-1:0] pt_speed(input logic [CFG_DATA_W-1:0] p);
		return p[SPEED_W-1:0];
	endfunction

endpackage

[rtl/core/fan_curve_monotone_interpolator.sv]
// Top level of the fan curve block: monotone cubic Hermite interpolation over configured points.
//
// Usage: pulse start with a temperature sample while busy is low; the sample is
// taken at that clock edge and busy rises until the result is ready, unless the
// result is given straight from idle. The result appears on fan_speed, marked by
// done for exactly one cycle; the receiver cannot stall it. A new transaction may
// start in the cycle done is high. Steps: with no points in use or a sample at or
// below the first point the result is given from idle; above the last point the
// last speed is read out; else the segment and its neighbors are gathered and a
// zero-width or reversed segment gives its upper speed. An interpolation runs the
// shared bit-serial divider, one quotient bit per cycle, for the ratio, the segment
// slope, each usable neighbor slope and each harmonic tangent. One multiplier serves
// the harmonic products, the basis and the weighted sum. Samples do not overlap.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once; index 0 is
// the point count, indexes 1 to 7 the points. Write only while busy is low.
// Reset: asynchronous, active low; the curve returns to its six default points.
module fan_curve_monotone_interpolator
	import fcmi_pkg::*;
#(
	parameter int unsigned MAX_POINTS = DEFAULT_MAX_POINTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TEMP_W-1:0]     temperature,
	output logic                  busy,
	output logic                  done,
	output logic [SPEED_W-1:0]    fan_speed,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_LAST = 5'd1;
	localparam logic [4:0] ST_GP   = 5'd2;
	localparam logic [4:0] ST_G0   = 5'd3;
	localparam logic [4:0] ST_G1   = 5'd4;
	localparam logic [4:0] ST_GN   = 5'd5;
	localparam logic [4:0] ST_CHK  = 5'd6;
	localparam logic [4:0] ST_DR   = 5'd7;
	localparam logic [4:0] ST_DM   = 5'd8;
	localparam logic [4:0] ST_DP   = 5'd9;
	localparam logic [4:0] ST_HM0  = 5'd10;
	localparam logic [4:0] ST_HD0  = 5'd11;
	localparam logic [4:0] ST_DN   = 5'd12;
	localparam logic [4:0] ST_HM1  = 5'd13;
	localparam logic [4:0] ST_HD1  = 5'd14;
	localparam logic [4:0] ST_R2   = 5'd15;
	localparam logic [4:0] ST_R3   = 5'd16;
	localparam logic [4:0] ST_BAS  = 5'd17;
	localparam logic [4:0] ST_A1   = 5'd18;
	localparam logic [4:0] ST_A2   = 5'd19;
	localparam logic [4:0] ST_A3   = 5'd20;
	localparam logic [4:0] ST_A4   = 5'd21;
	localparam logic [4:0] ST_A5   = 5'd22;
	localparam logic [4:0] ST_A6   = 5'd23;
	localparam logic [4:0] ST_FIN  = 5'd24;

	localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_POINTS);

	// Configuration registers.
	logic [COUNT_W-1:0]    count_q;
	logic [CFG_DATA_W-1:0] point_q [NUM_POINTS];

	// Sequencer and result registers.
	logic [4:0]            state_q;
	logic                  done_q;
	logic [SPEED_W-1:0]    fan_speed_q;
	logic [TEMP_W-1:0]     temp_q;
	logic [COUNT_W-1:0]    seg_q;

	// Gathered points of the segment and its neighbors.
	logic [TEMP_W-1:0]     tp_q, t0_q, t1_q, tn_q;
	logic [SPEED_W-1:0]    sp_q, s0_q, s1_q, sn_q;

	// Datapath registers.
	logic [16:0]           r_q;
	logic signed [32:0]    m_q, sl_q, tan0_q, tan1_q;
	logic [63:0]           prod_q;
	logic [31:0]           hsum_q;
	logic                  hneg_q;
	logic [32:0]           r2_q;
	logic [48:0]           r3_q;
	logic signed [17:0]    h00_q, h01_q, h10_q, h11_q;
	logic signed [29:0]    sh_q;
	logic signed [63:0]    acc_q;

	// Divider registers.
	logic                  div_run_q;
	logic [5:0]            div_cnt_q;
	logic [32:0]           rem_q;
	logic [63:0]           quo_q;
	logic [31:0]           dvs_q;

	// Combinational signals.
	logic [COUNT_W-1:0]    n_eff;
	logic                  seg_found;
	logic [COUNT_W-1:0]    seg_idx;
	logic [COUNT_W-1:0]    rd_addr;
	logic [CFG_DATA_W-1:0] rd_point;
	logic                  has_prev, has_next;
	logic signed [12:0]    span, ps, ns;
	logic                  prev_ok, next_ok;
	logic [13:0]           dm_mag, dp_mag, dn_mag;
	logic                  dm_neg, dp_neg, dn_neg;
	logic [31:0]           abs_m, abs_sl;
	logic                  harm_zero;
	logic [63:0]           div_dividend;
	logic [31:0]           div_divisor;
	logic [5:0]            div_k;
	logic [32:0]           div_t;
	logic                  div_ge;
	logic signed [32:0]    div_q_pos;
	logic signed [33:0]    mul_a, mul_b;
	logic signed [67:0]    mul_p;
	logic signed [63:0]    mul_lo;
	logic [51:0]           r2s, h01_raw, h10_raw, h11_raw;
	logic [51:0]           h01_rnd, h10_rnd, h11_rnd;
	logic signed [63:0]    lo_b, hi_b, acc_cl, acc_rnd;
	logic [SPEED_W-1:0]    s_min, s_max;

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign fan_speed = fan_speed_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			point_q <= POINT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_COUNT) begin
				count_q <= cfg_wdata[COUNT_W-1:0];
			end else begin
				point_q[cfg_index - REG_POINT0] <= cfg_wdata;
			end
		end
	end

	// Points in use, limited to the configured maximum.
	assign n_eff = (count_q > MAX_N) ? MAX_N : count_q;

	// Segment search: the first point at or above the sample closes the segment.
	always_comb begin
		seg_found = 1'b0;
		seg_idx   = '0;
		for (int k = NUM_POINTS - 1; k >= 1; k--) begin
			if ((COUNT_W'(k) < n_eff) && (temperature <= pt_temp(point_q[k]))) begin
				seg_found = 1'b1;
				seg_idx   = COUNT_W'(k);
			end
		end
	end

	// Single read port into the point registers for the gather steps.
	always_comb begin
		unique case (state_q)
			ST_GP:   rd_addr = (seg_q >= 3'd2) ? seg_q - 3'd2 : '0;
			ST_G0:   rd_addr = seg_q - 3'd1;
			ST_GN:   rd_addr = (seg_q < 3'(NUM_POINTS - 1)) ? seg_q + 3'd1 : seg_q;
			default: rd_addr = seg_q;
		endcase
	end
	assign rd_point = point_q[rd_addr];

	// Segment geometry and speed differences.
	assign has_prev = (seg_q > 3'd1);
	assign has_next = (({1'b0, seg_q} + 4'd1) < {1'b0, n_eff});
	assign span     = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
	assign ps       = $signed({1'b0, t0_q}) - $signed({1'b0, tp_q});
	assign ns       = $signed({1'b0, tn_q}) - $signed({1'b0, t1_q});
	assign prev_ok  = has_prev && (ps > 13'sd0);
	assign next_ok  = has_next && (ns > 13'sd0);

	assign dm_neg = (s1_q < s0_q);
	assign dm_mag = dm_neg ? s0_q - s1_q : s1_q - s0_q;
	assign dp_neg = (s0_q < sp_q);
	assign dp_mag = dp_neg ? sp_q - s0_q : s0_q - sp_q;
	assign dn_neg = (sn_q < s1_q);
	assign dn_mag = dn_neg ? s1_q - sn_q : sn_q - s1_q;

	// Harmonic mean operands; a zero or a sign change gives a flat tangent.
	assign abs_m     = m_q[32] ? 32'(-m_q) : 32'(m_q);
	assign abs_sl    = sl_q[32] ? 32'(-sl_q) : 32'(sl_q);
	assign harm_zero = (m_q == 33'sd0) || (sl_q == 33'sd0) || (m_q[32] != sl_q[32]);

	// Divider operand selection: the quotient is known to fit in div_k bits.
	always_comb begin
		unique case (state_q)
			ST_DR: begin
				div_dividend = {36'b0, temp_q - t0_q, 16'b0};
				div_divisor  = 32'(unsigned'(span));
				div_k        = 6'd17;
			end
			ST_DM: begin
				div_dividend = {34'b0, dm_mag, 16'b0};
				div_divisor  = 32'(unsigned'(span));
				div_k        = 6'd31;
			end
			ST_DP: begin
				div_dividend = {34'b0, dp_mag, 16'b0};
				div_divisor  = 32'(unsigned'(ps));
				div_k        = 6'd31;
			end
			ST_DN: begin
				div_dividend = {34'b0, dn_mag, 16'b0};
				div_divisor  = 32'(unsigned'(ns));
				div_k        = 6'd31;
			end
			default: begin
				div_dividend = {prod_q[62:0], 1'b0};
				div_divisor  = hsum_q;
				div_k        = 6'd32;
			end
		endcase
	end

	// One restoring division step per cycle.
	assign div_t     = {rem_q[31:0], quo_q[63]};
	assign div_ge    = (div_t >= {1'b0, dvs_q});
	assign div_q_pos = $signed({1'b0, quo_q[31:0]});

	// Shared multiplier operand selection.
	always_comb begin
		unique case (state_q)
			ST_HM0, ST_HM1: begin
				mul_a = $signed({2'b0, abs_sl});
				mul_b = $signed({2'b0, abs_m});
			end
			ST_R2: begin
				mul_a = $signed({17'b0, r_q});
				mul_b = $signed({17'b0, r_q});
			end
			ST_R3: begin
				mul_a = $signed({1'b0, r2_q});
				mul_b = $signed({17'b0, r_q});
			end
			ST_A1: begin
				mul_a = $signed({20'b0, s0_q});
				mul_b = 34'(h00_q);
			end
			ST_A2: begin
				mul_a = $signed({20'b0, s1_q});
				mul_b = 34'(h01_q);
			end
			ST_A3: begin
				mul_a = 34'(span);
				mul_b = 34'(h10_q);
			end
			ST_A5: begin
				mul_a = 34'(span);
				mul_b = 34'(h11_q);
			end
			ST_A4: begin
				mul_a = 34'(sh_q);
				mul_b = 34'(tan0_q);
			end
			default: begin
				mul_a = 34'(sh_q);
				mul_b = 34'(tan1_q);
			end
		endcase
	end
	assign mul_p  = mul_a * mul_b;
	assign mul_lo = $signed(mul_p[63:0]);

	// Hermite basis from r, r squared and r cubed, all in Q48, rounded to Q16.
	assign r2s     = {3'b0, r2_q, 16'b0};
	assign h01_raw = r2s + (r2s << 1) - ({3'b0, r3_q} << 1);
	assign h10_raw = {3'b0, r3_q} + ({35'b0, r_q} << 32) - (r2s << 1);
	assign h11_raw = r2s - {3'b0, r3_q};
	assign h01_rnd = h01_raw + 52'h0_0000_8000_0000;
	assign h10_rnd = h10_raw + 52'h0_0000_8000_0000;
	assign h11_rnd = h11_raw + 52'h0_0000_8000_0000;

	// Clamp to the segment speeds and round to an integer speed.
	assign s_min   = (s0_q < s1_q) ? s0_q : s1_q;
	assign s_max   = (s0_q < s1_q) ? s1_q : s0_q;
	assign lo_b    = $signed({18'b0, s_min, 32'b0});
	assign hi_b    = $signed({18'b0, s_max, 32'b0});
	assign acc_cl  = (acc_q < lo_b) ? lo_b : ((acc_q > hi_b) ? hi_b : acc_q);
	assign acc_rnd = acc_cl + 64'sh8000_0000;

	// Sequencer with the shared divider and multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			div_run_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						temp_q <= temperature;
						if (n_eff == '0) begin
							fan_speed_q <= FULL_SPEED;
							done_q      <= 1'b1;
						end else if (temperature <= pt_temp(point_q[0])) begin
							fan_speed_q <= pt_speed(point_q[0]);
							done_q      <= 1'b1;
						end else if (!seg_found) begin
							seg_q   <= n_eff - 3'd1;
							state_q <= ST_LAST;
						end else begin
							seg_q   <= seg_idx;
							state_q <= ST_GP;
						end
					end
				end
				ST_LAST: begin
					fan_speed_q <= pt_speed(rd_point);
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_GP: begin
					tp_q    <= pt_temp(rd_point);
					sp_q    <= pt_speed(rd_point);
					state_q <= ST_G0;
				end
				ST_G0: begin
					t0_q    <= pt_temp(rd_point);
					s0_q    <= pt_speed(rd_point);
					state_q <= ST_G1;
				end
				ST_G1: begin
					t1_q    <= pt_temp(rd_point);
					s1_q    <= pt_speed(rd_point);
					state_q <= ST_GN;
				end
				ST_GN: begin
					tn_q    <= pt_temp(rd_point);
					sn_q    <= pt_speed(rd_point);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// A zero-width or reversed segment gives the upper speed.
					if (span <= 13'sd0) begin
						fan_speed_q <= s1_q;
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_DR;
					end
				end
				ST_DR, ST_DM, ST_DP, ST_DN, ST_HD0, ST_HD1: begin
					if (!div_run_q) begin
						rem_q     <= 33'(div_dividend >> div_k);
						quo_q     <= div_dividend << (7'd64 - {1'b0, div_k});
						dvs_q     <= div_divisor;
						div_cnt_q <= div_k;
						div_run_q <= 1'b1;
					end else if (div_cnt_q != '0) begin
						rem_q     <= div_ge ? div_t - {1'b0, dvs_q} : div_t;
						quo_q     <= {quo_q[62:0], div_ge};
						div_cnt_q <= div_cnt_q - 6'd1;
					end else begin
						div_run_q <= 1'b0;
						unique case (state_q)
							ST_DR: begin
								r_q     <= quo_q[16:0];
								state_q <= ST_DM;
							end
							ST_DM: begin
								m_q    <= dm_neg ? -div_q_pos : div_q_pos;
								tan0_q <= dm_neg ? -div_q_pos : div_q_pos;
								tan1_q <= dm_neg ? -div_q_pos : div_q_pos;
								if (prev_ok) begin
									state_q <= ST_DP;
								end else if (next_ok) begin
									state_q <= ST_DN;
								end else begin
									state_q <= ST_R2;
								end
							end
							ST_DP: begin
								sl_q    <= dp_neg ? -div_q_pos : div_q_pos;
								state_q <= ST_HM0;
							end
							ST_DN: begin
								sl_q    <= dn_neg ? -div_q_pos : div_q_pos;
								state_q <= ST_HM1;
							end
							ST_HD0: begin
								tan0_q  <= hneg_q ? -div_q_pos : div_q_pos;
								state_q <= next_ok ? ST_DN : ST_R2;
							end
							default: begin
								tan1_q  <= hneg_q ? -div_q_pos : div_q_pos;
								state_q <= ST_R2;
							end
						endcase
					end
				end
				ST_HM0: begin
					prod_q <= mul_p[63:0];
					hsum_q <= abs_m + abs_sl;
					hneg_q <= m_q[32];
					if (harm_zero) begin
						tan0_q  <= '0;
						state_q <= next_ok ? ST_DN : ST_R2;
					end else begin
						state_q <= ST_HD0;
					end
				end
				ST_HM1: begin
					prod_q <= mul_p[63:0];
					hsum_q <= abs_m + abs_sl;
					hneg_q <= m_q[32];
					if (harm_zero) begin
						tan1_q  <= '0;
						state_q <= ST_R2;
					end else begin
						state_q <= ST_HD1;
					end
				end
				ST_R2: begin
					r2_q    <= mul_p[32:0];
					state_q <= ST_R3;
				end
				ST_R3: begin
					r3_q    <= mul_p[48:0];
					state_q <= ST_BAS;
				end
				ST_BAS: begin
					h01_q   <= $signed({1'b0, h01_rnd[48:32]});
					h00_q   <= 18'sd65536 - $signed({1'b0, h01_rnd[48:32]});
					h10_q   <= $signed({1'b0, h10_rnd[48:32]});
					h11_q   <= -$signed({1'b0, h11_rnd[48:32]});
					state_q <= ST_A1;
				end
				ST_A1: begin
					acc_q   <= mul_lo;
					state_q <= ST_A2;
				end
				ST_A2: begin
					acc_q   <= (acc_q + mul_lo) <<< 16;
					state_q <= ST_A3;
				end
				ST_A3: begin
					sh_q    <= mul_p[29:0];
					state_q <= ST_A4;
				end
				ST_A4: begin
					acc_q   <= acc_q + mul_lo;
					state_q <= ST_A5;
				end
				ST_A5: begin
					sh_q    <= mul_p[29:0];
					state_q <= ST_A6;
				end
				ST_A6: begin
					acc_q   <= acc_q + mul_lo;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					fan_speed_q <= acc_rnd[45:32];
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/fcmi_checker.sv]
// Port-level checker of the fan curve block and its bind to the top level.
`include "assert_macros.svh"

module fcmi_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// A result is only shown once the block is free again.
	`FCMI_ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !busy)

	// An accepted transaction either finishes at once or keeps the block busy.
	`FCMI_ASSERT_NXT(a_accept_progress, clk, arst_n, start && !busy, busy || done)

	// With nothing accepted and nothing in flight no result may appear.
	`FCMI_ASSERT_NXT(a_no_spurious, clk, arst_n, !busy && !start, !done)

	// The block only becomes busy through an accepted transaction.
	`FCMI_ASSERT_IMP(a_busy_from_start, clk, arst_n, $rose(busy), $past(start))

endmodule

bind fan_curve_monotone_interpolator fcmi_checker u_fcmi_checker (.*);

[bench/tb.sv]
// Testbench for the fan curve block: directed and random samples against a built-in predictor.
`timescale 1ns / 100ps

module tb;
	import fcmi_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 250;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic [TEMP_W-1:0]     temperature;
	logic                  busy;
	logic                  done;
	logic [SPEED_W-1:0]    fan_speed;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Shadow copy of the curve registers.
	logic [COUNT_W-1:0]    curve_count;
	logic [CFG_DATA_W-1:0] curve_point [NUM_POINTS];

	logic [SPEED_W-1:0] speed_queue [$];
	int  mismatches;
	int  quiet_cycles;
	bit  quiet_stretch;

	fan_curve_monotone_interpolator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .temperature(temperature),
		.busy(busy), .done(done), .fan_speed(fan_speed),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Slope of a segment in Q16, truncated toward zero.
	function automatic longint seg_slope(longint diff, longint span);
		longint mag;
		mag = (diff < 0) ? -diff : diff;
		mag = (mag <<< 16) / span;
		return (diff < 0) ? -mag : mag;
	endfunction

	// Harmonic mean of two slopes, zero when they disagree in sign or one is flat.
	function automatic longint harmonic_slope(longint a, longint b);
		longint ua, ub, q;
		if (a == 0 || b == 0 || ((a < 0) != (b < 0)))
			return 0;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		q = (2 * ua * ub) / (ua + ub);
		return (a < 0) ? -q : q;
	endfunction

	// Expected fan speed for one sample under the current shadow curve.
	function automatic logic [SPEED_W-1:0] predict_speed(logic [TEMP_W-1:0] sample);
		longint tp [NUM_POINTS];
		longint sp [NUM_POINTS];
		longint t, span, m, tan0, tan1, lo, hi, acc, ps, ns;
		longint h00q, h01q, h10q, h11q;
		longint unsigned r, r2, r3, h01, h10, h11m, rounded;
		int n;
		n = curve_count;
		if (n > NUM_POINTS)
			n = NUM_POINTS;
		for (int k = 0; k < NUM_POINTS; k++) begin
			tp[k] = pt_temp(curve_point[k]);
			sp[k] = pt_speed(curve_point[k]);
		end
		t = sample;
		if (n == 0)
			return FULL_SPEED;
		if (t <= tp[0])
			return sp[0][SPEED_W-1:0];
		for (int i = 1; i < n; i++) begin
			if (t > tp[i])
				continue;
			span = tp[i] - tp[i-1];
			if (span <= 0)
				return sp[i][SPEED_W-1:0];
			r = longint'((t - tp[i-1]) <<< 16) / span;
			m = seg_slope(sp[i] - sp[i-1], span);
			tan0 = m;
			tan1 = m;
			if (i > 1) begin
				ps = tp[i-1] - tp[i-2];
				if (ps > 0)
					tan0 = harmonic_slope(seg_slope(sp[i-1] - sp[i-2], ps), m);
			end
			if (i + 1 < n) begin
				ns = tp[i+1] - tp[i];
				if (ns > 0)
					tan1 = harmonic_slope(m, seg_slope(sp[i+1] - sp[i], ns));
			end
			// Hermite basis in Q48, rounded to Q16.
			r2 = r * r;
			r3 = r2 * r;
			h01 = 3 * (r2 << 16) - 2 * r3;
			h10 = r3 + (r << 32) - 2 * (r2 << 16);
			h11m = (r2 << 16) - r3;
			h01q = longint'((h01 + 64'h8000_0000) >> 32);
			h10q = longint'((h10 + 64'h8000_0000) >> 32);
			h11q = -longint'((h11m + 64'h8000_0000) >> 32);
			h00q = 65536 - h01q;
			acc = (sp[i-1] * h00q + sp[i] * h01q) * 65536
				+ span * tan0 * h10q + span * tan1 * h11q;
			lo = ((sp[i-1] < sp[i]) ? sp[i-1] : sp[i]) <<< 32;
			hi = ((sp[i-1] < sp[i]) ? sp[i] : sp[i-1]) <<< 32;
			if (acc < lo)
				acc = lo;
			if (acc > hi)
				acc = hi;
			rounded = (longint'(acc) + 64'h8000_0000) >> 32;
			return rounded[SPEED_W-1:0];
		end
		return sp[n-1][SPEED_W-1:0];
	endfunction

	// Check each result against the oldest expected speed.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (speed_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: fan_speed=%0d", fan_speed);
			end else if (fan_speed !== speed_queue[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected fan_speed=%0d actual=%0d",
						speed_queue[0], fan_speed);
				void'(speed_queue.pop_front());
			end else begin
				void'(speed_queue.pop_front());
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Send one sample; start stays high so a following sample can go back to back.
	task automatic send_sample(input logic [TEMP_W-1:0] sample);
		forever begin
			if (!busy) begin
				start <= 1'b1;
				temperature <= sample;
				break;
			end
			start <= 1'b0;
			temperature <= TEMP_W'($urandom);
			@(negedge clk);
		end
		@(negedge clk);
		speed_queue.push_back(predict_speed(sample));
	endtask

	task automatic idle_cycles(input int count);
		start <= 1'b0;
		temperature <= TEMP_W'($urandom);
		repeat (count) @(negedge clk);
	endtask

	task automatic maybe_idle();
		if (!quiet_stretch && $urandom_range(99) < 6)
			idle_cycles($urandom_range(8, 1));
	endtask

	// Wait until every expected result has arrived and the block is idle.
	task automatic drain();
		idle_cycles(1);
		while (speed_queue.size() != 0 || busy)
			@(negedge clk);
	endtask

	// Write the whole curve once the block is drained.
	task automatic load_curve(input logic [COUNT_W-1:0] count,
			input logic [CFG_DATA_W-1:0] pts [NUM_POINTS]);
		drain();
		curve_count = count;
		cfg_we <= 1'b1;
		cfg_index <= REG_COUNT;
		cfg_wdata <= {{(CFG_DATA_W-COUNT_W){1'b0}}, count};
		@(negedge clk);
		for (int k = 0; k < NUM_POINTS; k++) begin
			curve_point[k] = pts[k];
			cfg_index <= REG_POINT0 + CFG_IDX_W'(k);
			cfg_wdata <= pts[k];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pack_point(int t, int s);
		return {TEMP_W'(t), SPEED_W'(s)};
	endfunction

	// Sample near the curve, on a point, or anywhere.
	function automatic logic [TEMP_W-1:0] pick_sample();
		int lo_t, hi_t, n;
		n = (curve_count == 0) ? 1 : curve_count;
		lo_t = pt_temp(curve_point[0]);
		hi_t = pt_temp(curve_point[n-1]);
		if (hi_t < lo_t)
			hi_t = lo_t;
		case ($urandom_range(9))
			0: return TEMP_W'($urandom);
			1: return pt_temp(curve_point[$urandom_range(n-1)]);
			default: begin
				lo_t = (lo_t > 16) ? lo_t - 16 : 0;
				hi_t = (hi_t < 4079) ? hi_t + 16 : 4095;
				return TEMP_W'($urandom_range(hi_t, lo_t));
			end
		endcase
	endfunction

	task automatic test_reset_curve();
		logic [TEMP_W-1:0] samples [9] = '{0, 639, 640, 641, 800, 1100, 1440, 1441, 4095};
		curve_count = COUNT_RESET;
		curve_point = POINT_RESET;
		foreach (samples[k])
			send_sample(samples[k]);
	endtask

	task automatic test_special_cases();
		logic [CFG_DATA_W-1:0] pts [NUM_POINTS];
		// No points in use gives full speed.
		pts = POINT_RESET;
		load_curve(0, pts);
		send_sample(0);
		send_sample(4095);
		// One point: below and above it.
		pts[0] = pack_point(2000, 5000);
		load_curve(1, pts);
		send_sample(1999);
		send_sample(2001);
		// Zero-width and reversed segments, speeds above full scale.
		pts = '{pack_point(100, 0), pack_point(100, 16383), pack_point(500, 9000),
			pack_point(400, 2000), pack_point(900, 12000), pack_point(1500, 100),
			pack_point(4095, 16383)};
		load_curve(7, pts);
		send_sample(100);
		send_sample(101);
		send_sample(450);
		send_sample(700);
		send_sample(1200);
		send_sample(4094);
		send_sample(4095);
		// Full extremes of the point fields.
		pts = '{pack_point(0, 0), pack_point(1, 16383), pack_point(2048, 0),
			pack_point(4094, 16383), pack_point(4095, 0), pack_point(4095, 16383),
			pack_point(4095, 16383)};
		load_curve(7, pts);
		send_sample(1);
		send_sample(1000);
		send_sample(3000);
		send_sample(4095);
	endtask

	// Random curves, mostly ascending and monotone, with some malformed ones.
	task automatic test_random_curves();
		logic [CFG_DATA_W-1:0] pts [NUM_POINTS];
		logic [COUNT_W-1:0] count;
		int t, s, shape;
		for (int c = 0; c < 30; c++) begin
			shape = $urandom_range(9);
			count = COUNT_W'((shape == 0) ? $urandom : $urandom_range(7, 2));
			t = $urandom_range(1500);
			s = $urandom_range(4000);
			for (int k = 0; k < NUM_POINTS; k++) begin
				if (shape == 1) begin
					pts[k] = CFG_DATA_W'($urandom);
				end else begin
					pts[k] = pack_point(t, s);
					t += ($urandom_range(7) == 0) ? 0 : $urandom_range(600, 1);
					if (t > 4095)
						t = 4095;
					if (shape == 2)
						s = $urandom_range(16383);
					else
						s += $urandom_range(2500);
					if (s > 16383)
						s = 16383;
				end
			end
			load_curve(count, pts);
			quiet_stretch = (c == 5);
			for (int j = 0; j < 65; j++) begin
				send_sample(pick_sample());
				maybe_idle();
			end
			quiet_stretch = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		temperature = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		mismatches = 0;
		quiet_stretch = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_curve();
		test_special_cases();
		test_random_curves();
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && speed_queue.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
